/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the given reset is low.
`define ASAS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define ASAS_ASSERT(label, prop, msg) \
  `ASAS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/asas_pkg.sv */
package asas_pkg;

  localparam int CNT_W     = 16;  // sample_count and pass counter
  localparam int MASK_W    = 8;   // channel_mask
  localparam int CH_OUT_W  = 3;   // channel field of a result word
  localparam int SUM_W     = 26;  // running sum, saturating
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 1'b1;

  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 16'd1;
  localparam logic [MASK_W-1:0] CHANNEL_MASK_RST = 8'd0;

  // Scan sequencer phases
  typedef enum logic [2:0] {
    PH_ADVANCE   = 3'd0,
    PH_START     = 3'd1,
    PH_WAIT_IDLE = 3'd2,
    PH_WAIT_DONE = 3'd3,
    PH_FINISH    = 3'd4
  } phase_e;

  // Engine states of the top level
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_ACC,
    ENG_EMIT,
    ENG_PUB_RD,
    ENG_PUB_OUT
  } eng_e;

  // What one poll tick asks of the engine
  typedef struct packed {
    logic publish;
    logic accumulate;
    logic start_conv;
    logic clear_done;
  } step_t;

endpackage

/* rtl/asas_in_if.sv */
interface asas_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   conv_busy;
  logic                   conv_done;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, conv_busy, conv_done, sample, input ready);
  modport sink   (input valid, conv_busy, conv_done, sample, output ready);
endinterface

/* rtl/asas_out_if.sv */
interface asas_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [asas_pkg::CH_OUT_W-1:0] channel;
  logic                          start_conversion;
  logic                          clear_done;
  logic [asas_pkg::SUM_W-1:0]    sum_value;
  logic                          last;

  modport source (output valid, kind, channel, start_conversion, clear_done, sum_value, last,
                  input ready);
  modport sink   (input valid, kind, channel, start_conversion, clear_done, sum_value, last,
                  output ready);
endinterface

/* rtl/adc_scan_accumulate_sequencer_unit.sv */
// Round-robin converter scan sequencer with per-channel sample accumulation.
//
// in_i  : one word per poll tick (conv_busy, conv_done, sample).
// out_o : result words. A normal tick gives one control word (kind 0, last 1)
//         with the selected channel and the start / clear strobes. A tick that
//         closes the last pass gives CHANNELS sum words (kind 1) in channel
//         order, the final one marked last, and the sums restart from zero.
// cfg_* : register writes, index 0 sample_count, 1 channel_mask; only while idle.
//
// Timing: ready is high whenever the engine is idle, even if a result word is
// still waiting in the output register. The control word of a taken tick is
// loaded there from the emit state, entered through the accumulate state when
// the sample is added to its sum (read, then saturating write of the sum
// memory). No new tick is taken until the engine is idle. A publish tick reads
// the sum memory entry by entry and holds the input until its last sum word is
// loaded. A stalled receiver holds the output register; the engine waits on it.
// Reset: sequencer at the advance phase on the last channel, pass count zero,
// all sums read as zero (entry valid bits, no clearing pass), sample_count 1,
// channel_mask 0.
module adc_scan_accumulate_sequencer_unit #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  asas_in_if.sink                         in_i,
  asas_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [asas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [asas_pkg::CNT_W-1:0]      cfg_data_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW   = asas_pkg::SUM_W;

  // config registers
  logic [asas_pkg::CNT_W-1:0]  sample_count_q;
  logic [asas_pkg::MASK_W-1:0] channel_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= asas_pkg::SAMPLE_COUNT_RST;
      channel_mask_q <= asas_pkg::CHANNEL_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asas_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i;
        asas_pkg::CFG_CHANNEL_MASK: channel_mask_q <= cfg_data_i[asas_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // engine control
  asas_pkg::eng_e  state_q, state_d;
  logic            in_ready, accept, slot_free;
  logic            rd_en, we, clr_all, load_ctl, load_pub;
  logic [CH_W-1:0] rd_addr;

  // sequencer
  logic [CH_W-1:0] seq_chan, seq_chan_next;
  asas_pkg::step_t step;

  asas_seq #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (accept),
    .conv_busy_i    (in_i.conv_busy),
    .conv_done_i    (in_i.conv_done),
    .sample_count_i (sample_count_q),
    .channel_mask_i (channel_mask_q),
    .chan_o         (seq_chan),
    .chan_next_o    (seq_chan_next),
    .step_o         (step)
  );

  // sum store; accumulate is read at accept, written back the next cycle,
  // and no new tick is taken before the write, so no forwarding is needed
  logic [SW-1:0]   rd_data, wr_data;
  logic [SW:0]     acc_sum;
  logic [SAMPLE_BITS-1:0] sample_q;

  assign acc_sum = {1'b0, rd_data} + (SW + 1)'(sample_q);
  assign wr_data = acc_sum[SW] ? '1 : acc_sum[SW-1:0];   // saturate

  asas_sum_mem #(
    .DEPTH (CHANNELS),
    .AW    (CH_W),
    .DW    (SW)
  ) u_sum_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .we_i      (we),
    .wr_addr_i (seq_chan),
    .wr_data_i (wr_data),
    .clr_all_i (clr_all)
  );

  // publish walk
  logic [CH_W-1:0] pub_idx_q;
  logic            pub_last;

  assign pub_last = (pub_idx_q == CH_W'(CHANNELS - 1));

  // output register
  logic                           out_valid_q, out_valid_d;
  logic                           out_kind_q, out_start_q, out_clr_q, out_last_q;
  logic [asas_pkg::CH_OUT_W-1:0]  out_chan_q;
  logic [SW-1:0]                  out_sum_q;

  // pending control word of the current tick
  logic [asas_pkg::CH_OUT_W-1:0]  res_chan_q;
  logic                           res_start_q, res_clr_q;

  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      asas_pkg::ENG_IDLE: begin
        if (accept) begin
          if (step.publish) begin
            state_d = asas_pkg::ENG_PUB_RD;
          end else if (step.accumulate) begin
            state_d = asas_pkg::ENG_ACC;
          end else begin
            state_d = asas_pkg::ENG_EMIT;
          end
        end
      end
      asas_pkg::ENG_ACC:    state_d = asas_pkg::ENG_EMIT;
      asas_pkg::ENG_EMIT: begin
        if (slot_free) begin
          state_d = asas_pkg::ENG_IDLE;
        end
      end
      asas_pkg::ENG_PUB_RD: state_d = asas_pkg::ENG_PUB_OUT;
      asas_pkg::ENG_PUB_OUT: begin
        if (slot_free) begin
          state_d = pub_last ? asas_pkg::ENG_IDLE : asas_pkg::ENG_PUB_RD;
        end
      end
      default: state_d = asas_pkg::ENG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = seq_chan;
    we       = 1'b0;
    load_ctl = 1'b0;
    load_pub = 1'b0;
    case (state_q)
      asas_pkg::ENG_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_i.valid && step.accumulate;
      end
      asas_pkg::ENG_ACC:     we       = 1'b1;
      asas_pkg::ENG_EMIT:    load_ctl = slot_free;
      asas_pkg::ENG_PUB_RD: begin
        rd_en   = 1'b1;
        rd_addr = pub_idx_q;
      end
      asas_pkg::ENG_PUB_OUT: load_pub = slot_free;
      default: ;
    endcase
  end

  assign clr_all     = load_pub && pub_last;
  assign in_i.ready  = in_ready;
  assign out_valid_d = (load_ctl || load_pub) ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asas_pkg::ENG_IDLE;
      pub_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (load_pub) begin
        pub_idx_q <= pub_last ? '0 : pub_idx_q + CH_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q    <= in_i.sample;
      res_chan_q  <= asas_pkg::CH_OUT_W'(seq_chan_next);
      res_start_q <= step.start_conv;
      res_clr_q   <= step.clear_done;
    end
    if (load_ctl) begin
      out_kind_q  <= 1'b0;
      out_chan_q  <= res_chan_q;
      out_start_q <= res_start_q;
      out_clr_q   <= res_clr_q;
      out_sum_q   <= '0;
      out_last_q  <= 1'b1;
    end else if (load_pub) begin
      out_kind_q  <= 1'b1;
      out_chan_q  <= asas_pkg::CH_OUT_W'(pub_idx_q);
      out_start_q <= 1'b0;
      out_clr_q   <= 1'b0;
      out_sum_q   <= rd_data;
      out_last_q  <= pub_last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = out_kind_q;
  assign out_o.channel          = out_chan_q;
  assign out_o.start_conversion = out_start_q;
  assign out_o.clear_done       = out_clr_q;
  assign out_o.sum_value        = out_sum_q;
  assign out_o.last             = out_last_q;

endmodule

/* rtl/asas_sum_mem.sv */
module asas_sum_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          clr_all_i
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DW-1:0]    rdata_q;
  logic [DEPTH-1:0] valid_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // entry valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clr_all_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/asas_seq.sv */
module asas_seq #(
  parameter int CHANNELS = 8,
  parameter int CH_W     = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_en_i,
  input  logic                         conv_busy_i,
  input  logic                         conv_done_i,
  input  logic [asas_pkg::CNT_W-1:0]   sample_count_i,
  input  logic [asas_pkg::MASK_W-1:0]  channel_mask_i,
  output logic [CH_W-1:0]              chan_o,
  output logic [CH_W-1:0]              chan_next_o,
  output asas_pkg::step_t              step_o
);

  asas_pkg::phase_e             phase_q, phase_d;
  logic [CH_W-1:0]              chan_q, chan_d, chan_adv;
  logic [asas_pkg::CNT_W-1:0]   pass_q, pass_d;
  logic [asas_pkg::CNT_W:0]     pass_inc;
  logic [2:0]                   mask_idx;
  logic                         wrap, enabled;
  asas_pkg::step_t              step;

  always_comb begin
    wrap     = (chan_q == CH_W'(CHANNELS - 1));
    chan_adv = wrap ? '0 : chan_q + CH_W'(1);
    // compare before truncation: a full counter always publishes
    pass_inc = {1'b0, pass_q} + (asas_pkg::CNT_W + 1)'(1);
    mask_idx = 3'(chan_adv);
    enabled  = (int'(chan_adv) < asas_pkg::MASK_W) && channel_mask_i[mask_idx];

    phase_d = phase_q;
    chan_d  = chan_q;
    pass_d  = pass_q;
    step    = '0;
    case (phase_q)
      asas_pkg::PH_ADVANCE: begin
        chan_d = chan_adv;
        if (wrap) begin
          if (pass_inc > {1'b0, sample_count_i}) begin
            pass_d       = asas_pkg::CNT_W'(1);
            step.publish = 1'b1;
          end else begin
            pass_d = pass_inc[asas_pkg::CNT_W-1:0];
          end
        end
        if (enabled) begin
          phase_d = asas_pkg::PH_START;
        end
      end
      asas_pkg::PH_START: begin
        if (!conv_busy_i) begin
          step.start_conv = 1'b1;
          phase_d         = asas_pkg::PH_WAIT_IDLE;
        end
      end
      asas_pkg::PH_WAIT_IDLE: begin
        if (!conv_busy_i) begin
          phase_d = asas_pkg::PH_WAIT_DONE;
        end
      end
      asas_pkg::PH_WAIT_DONE: begin
        if (conv_done_i) begin
          step.clear_done = 1'b1;
          step.accumulate = 1'b1;
          phase_d         = asas_pkg::PH_FINISH;
        end
      end
      default: begin
        phase_d = asas_pkg::PH_ADVANCE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= asas_pkg::PH_ADVANCE;
      chan_q  <= CH_W'(CHANNELS - 1);
      pass_q  <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      pass_q  <= pass_d;
    end
  end

  assign chan_o      = chan_q;
  assign chan_next_o = chan_d;
  assign step_o      = step;

endmodule

/* rtl/asas_chk.sv */
`include "assert_macros.svh"

module asas_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_kind_i,
  input logic                         out_start_i,
  input logic                         out_clr_i,
  input logic [asas_pkg::SUM_W-1:0]   out_sum_i,
  input logic                         out_last_i
);

  // stalled word holds
  `ASAS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) && $stable(out_sum_i) && $stable(out_last_i), "stalled output word changed")

  // control word is single and carries no sum
  `ASAS_ASSERT(a_ctl_word, out_valid_i && !out_kind_i |-> out_last_i && (out_sum_i == '0), "control word not last or has a sum")

  // sum word carries no strobes
  `ASAS_ASSERT(a_sum_word, out_valid_i && out_kind_i |-> !out_start_i && !out_clr_i, "sum word with strobes")

  // no tick taken in the middle of a publish burst
  `ASAS_ASSERT(a_pub_busy, out_valid_i && out_kind_i && !out_last_i |-> !in_ready_i, "input ready during publish")

  // one tick at a time
  `ASAS_ASSERT(a_one_tick, in_valid_i && in_ready_i |=> !in_ready_i, "ready right after a taken tick")

endmodule

bind adc_scan_accumulate_sequencer_unit asas_chk u_asas_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_start_i (out_o.start_conversion),
  .out_clr_i   (out_o.clear_done),
  .out_sum_i   (out_o.sum_value),
  .out_last_i  (out_o.last)
);
